// ----- design/dtq_pkg.sv -----
// Shared types and constants of the deadline timer queue.
`default_nettype none
package dtq_pkg;
  localparam int TIMER_SLOTS = 32;
  localparam int SLOT_W      = $clog2(TIMER_SLOTS);
  localparam int CNT_W       = $clog2(TIMER_SLOTS + 1);
  localparam int TIME_W      = 48;
  localparam int TMO_W       = 32;
  localparam int ID_W        = 16;
  localparam int WAIT_W      = 31;
  localparam int OSLOT_W     = 5;
  localparam int TGT_W       = 5;
  localparam int MAX_EVENTS  = 32;
  localparam int EVT_W       = $clog2(MAX_EVENTS + 1);

  typedef enum logic [1:0] {
    CMD_ADD, CMD_DELETE, CMD_EXPIRE, CMD_QUERY
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_ADDED, KIND_EXPIRED, KIND_WAIT, KIND_DONE, KIND_FULL
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ADD, ST_SCAN, ST_EVAL, ST_DONE
  } state_e;

  typedef struct packed {
    logic              action;
    logic [ID_W-1:0]   owner;
    logic [TIME_W-1:0] deadline;
  } entry_t;
endpackage
`default_nettype wire

// ----- design/dtq_store.sv -----
// Timer entry memory: one write port, one registered read port.
`default_nettype none
module dtq_store (
  input  wire logic                      clk_i,
  input  wire logic                      we_i,
  input  wire logic [dtq_pkg::SLOT_W-1:0] waddr_i,
  input  wire dtq_pkg::entry_t           wdata_i,
  input  wire logic [dtq_pkg::SLOT_W-1:0] raddr_i,
  output dtq_pkg::entry_t                rdata_o
);
  import dtq_pkg::*;

  entry_t mem_q [TIMER_SLOTS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ----- design/deadline_timer_queue.sv -----
// Top level of the deadline timer queue: command sequencer, slot flags and min scan.
// Delete is absorbed in the accept cycle; add goes through ST_ADD. Query and expire
// find the queue front by scanning every slot through the single read port of the
// entry memory and one shared 48-bit compare, then evaluate the front. Every deleted
// or expired front entry costs one more scan. No clearing pass after reset: slot
// flags live in flip-flops.
`default_nettype none
module deadline_timer_queue (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [1:0]                  command_i,
  input  wire logic [dtq_pkg::TIME_W-1:0]  now_ms_i,
  input  wire logic [dtq_pkg::TMO_W-1:0]   timeout_ms_i,
  input  wire logic [dtq_pkg::ID_W-1:0]    request_id_i,
  input  wire logic                        has_action_i,
  input  wire logic [dtq_pkg::TGT_W-1:0]   target_slot_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [2:0]                       result_kind_o,
  output logic [dtq_pkg::OSLOT_W-1:0]      slot_o,
  output logic [dtq_pkg::ID_W-1:0]         owner_id_o,
  output logic [dtq_pkg::WAIT_W-1:0]       wait_ms_o,
  output logic                             wait_infinite_o,
  output logic                             last_o
);
  import dtq_pkg::*;

  state_e                 state_q, state_d;
  cmd_e                   cmd_q, cmd_d;
  logic [TIME_W-1:0]      now_q, now_d;
  logic [TMO_W-1:0]       tmo_q, tmo_d;
  logic [ID_W-1:0]        rid_q, rid_d;
  logic                   act_q, act_d;
  logic [TIMER_SLOTS-1:0] used_q, used_d, del_q, del_d;
  logic [CNT_W-1:0]       idx_q, idx_d;
  logic                   pv_q, pv_d;
  logic [SLOT_W-1:0]      pidx_q, pidx_d;
  logic                   bv_q, bv_d;
  logic [SLOT_W-1:0]      bidx_q, bidx_d;
  entry_t                 best_q, best_d;
  logic [EVT_W-1:0]       events_q, events_d;

  logic                   ov_q, ov_d;
  kind_e                  okind_q, okind_d;
  logic [OSLOT_W-1:0]     oslot_q, oslot_d;
  logic [ID_W-1:0]        oown_q, oown_d;
  logic [WAIT_W-1:0]      owait_q, owait_d;
  logic                   oinf_q, oinf_d, olast_q, olast_d;

  logic                   out_free, accept;
  logic                   free_found;
  logic [SLOT_W-1:0]      free_idx;
  logic [TIME_W:0]        dl_sum;
  logic [TIME_W-1:0]      dl_sat, diff;
  logic                   due;
  logic [WAIT_W-1:0]      wait_val;
  logic                   we;
  entry_t                 wdata, rdata;

  dtq_store u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (free_idx),
    .wdata_i (wdata),
    .raddr_i (idx_q[SLOT_W-1:0]),
    .rdata_o (rdata)
  );

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  assign dl_sum   = (TIME_W+1)'(now_q) + (TIME_W+1)'(tmo_q);
  assign dl_sat   = dl_sum[TIME_W] ? '1 : dl_sum[TIME_W-1:0];
  assign wdata    = '{action: act_q, owner: rid_q, deadline: dl_sat};
  assign due      = best_q.deadline <= now_q;
  assign diff     = best_q.deadline - now_q;
  assign wait_val = due ? '0 : ((|diff[TIME_W-1:WAIT_W]) ? '1 : diff[WAIT_W-1:0]);

  assign out_free   = !ov_q || !out_stall_i;
  assign in_stall_o = state_q != ST_IDLE;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;
    now_d    = now_q;
    tmo_d    = tmo_q;
    rid_d    = rid_q;
    act_d    = act_q;
    used_d   = used_q;
    del_d    = del_q;
    idx_d    = idx_q;
    pv_d     = 1'b0;
    pidx_d   = pidx_q;
    bv_d     = bv_q;
    bidx_d   = bidx_q;
    best_d   = best_q;
    events_d = events_q;
    we       = 1'b0;
    ov_d     = ov_q && out_stall_i;
    okind_d  = okind_q;
    oslot_d  = oslot_q;
    oown_d   = oown_q;
    owait_d  = owait_q;
    oinf_d   = oinf_q;
    olast_d  = olast_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_d    = cmd_e'(command_i);
          now_d    = now_ms_i;
          tmo_d    = timeout_ms_i;
          rid_d    = request_id_i;
          act_d    = has_action_i;
          events_d = '0;
          idx_d    = '0;
          bv_d     = 1'b0;
          unique case (cmd_e'(command_i))
            CMD_ADD:    state_d = ST_ADD;
            CMD_DELETE: begin
              if (7'(target_slot_i) < 7'(TIMER_SLOTS)
                  && used_q[SLOT_W'(target_slot_i)]) begin
                del_d[SLOT_W'(target_slot_i)] = 1'b1;
              end
            end
            CMD_EXPIRE, CMD_QUERY: state_d = ST_SCAN;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_ADD: begin
        if (out_free) begin
          ov_d    = 1'b1;
          oslot_d = '0;
          oown_d  = '0;
          owait_d = '0;
          oinf_d  = 1'b0;
          olast_d = 1'b1;
          if (free_found) begin
            we               = 1'b1;
            used_d[free_idx] = 1'b1;
            del_d[free_idx]  = 1'b0;
            okind_d          = KIND_ADDED;
            oslot_d          = OSLOT_W'(free_idx);
          end else begin
            okind_d = KIND_FULL;
          end
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        // read issued at idx_q, data compared in the next cycle
        if (idx_q < CNT_W'(TIMER_SLOTS)) begin
          pv_d   = 1'b1;
          pidx_d = idx_q[SLOT_W-1:0];
          idx_d  = idx_q + 1'b1;
        end
        if (pv_q && used_q[pidx_q] && (!bv_q || rdata.deadline < best_q.deadline)) begin
          bv_d   = 1'b1;
          bidx_d = pidx_q;
          best_d = rdata;
        end
        if (!pv_q && idx_q == CNT_W'(TIMER_SLOTS)) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        idx_d = '0;
        bv_d  = 1'b0;
        if (!bv_q) begin
          if (cmd_q == CMD_QUERY) begin
            if (out_free) begin
              ov_d    = 1'b1;
              okind_d = KIND_WAIT;
              oslot_d = '0;
              oown_d  = '0;
              owait_d = '0;
              oinf_d  = 1'b1;
              olast_d = 1'b1;
              state_d = ST_IDLE;
            end
          end else begin
            state_d = ST_DONE;
          end
        end else if (del_q[bidx_q]) begin
          used_d[bidx_q] = 1'b0;
          del_d[bidx_q]  = 1'b0;
          state_d        = ST_SCAN;
        end else if (cmd_q == CMD_QUERY) begin
          if (out_free) begin
            ov_d    = 1'b1;
            okind_d = KIND_WAIT;
            oslot_d = '0;
            oown_d  = '0;
            owait_d = wait_val;
            oinf_d  = 1'b0;
            olast_d = 1'b1;
            state_d = ST_IDLE;
          end else begin
            bv_d = bv_q;
          end
        end else if (!due) begin
          state_d = ST_DONE;
        end else if (best_q.action) begin
          if (out_free) begin
            ov_d           = 1'b1;
            okind_d        = KIND_EXPIRED;
            oslot_d        = OSLOT_W'(bidx_q);
            oown_d         = best_q.owner;
            owait_d        = '0;
            oinf_d         = 1'b0;
            olast_d        = 1'b0;
            used_d[bidx_q] = 1'b0;
            del_d[bidx_q]  = 1'b0;
            events_d       = events_q + 1'b1;
            state_d        = (events_d == EVT_W'(MAX_EVENTS)) ? ST_DONE : ST_SCAN;
          end else begin
            bv_d = bv_q;
          end
        end else begin
          used_d[bidx_q] = 1'b0;
          del_d[bidx_q]  = 1'b0;
          state_d        = ST_SCAN;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          ov_d    = 1'b1;
          okind_d = KIND_DONE;
          oslot_d = '0;
          oown_d  = '0;
          owait_d = '0;
          oinf_d  = 1'b0;
          olast_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      used_q   <= '0;
      del_q    <= '0;
      pv_q     <= 1'b0;
      bv_q     <= 1'b0;
      idx_q    <= '0;
      events_q <= '0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      used_q   <= used_d;
      del_q    <= del_d;
      pv_q     <= pv_d;
      bv_q     <= bv_d;
      idx_q    <= idx_d;
      events_q <= events_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    now_q   <= now_d;
    tmo_q   <= tmo_d;
    rid_q   <= rid_d;
    act_q   <= act_d;
    pidx_q  <= pidx_d;
    bidx_q  <= bidx_d;
    best_q  <= best_d;
    okind_q <= okind_d;
    oslot_q <= oslot_d;
    oown_q  <= oown_d;
    owait_q <= owait_d;
    oinf_q  <= oinf_d;
    olast_q <= olast_d;
  end

  assign out_valid_o     = ov_q;
  assign result_kind_o   = okind_q;
  assign slot_o          = oslot_q;
  assign owner_id_o      = oown_q;
  assign wait_ms_o       = owait_q;
  assign wait_infinite_o = oinf_q;
  assign last_o          = olast_q;
endmodule
`default_nettype wire

// ----- design/dtq_checker.sv -----
// Port-level checks of the deadline timer queue and their binding.
`default_nettype none
module dtq_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_stall_o,
  input wire logic [1:0]                  command_i,
  input wire logic                        out_valid_o,
  input wire logic                        out_stall_i,
  input wire logic [2:0]                  result_kind_o,
  input wire logic [dtq_pkg::WAIT_W-1:0]  wait_ms_o,
  input wire logic                        wait_infinite_o,
  input wire logic                        last_o
);
  import dtq_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_kind_o) && $stable(last_o))
    else $error("stalled result word changed");

  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> result_kind_o <= KIND_FULL)
    else $error("bad result kind");

  a_inf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && wait_infinite_o |-> result_kind_o == KIND_WAIT && wait_ms_o == '0)
    else $error("infinite wait on wrong word");

  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> last_o == (result_kind_o != KIND_EXPIRED))
    else $error("last flag mismatch");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && command_i != CMD_DELETE |=> in_stall_o)
    else $error("took a word while busy");
endmodule

bind deadline_timer_queue dtq_checker u_dtq_checker (.*);
`default_nettype wire
